FILE: src/mtev_pkg.sv
// mtev_pkg: shared widths, codes and controller/datapath interface types
// for the max-tree extinction value block. No dependencies.
`default_nettype none
package mtev_pkg;

	localparam int NODE_W        = 16;
	localparam int CNT_W         = 17;
	localparam int OUT_ATTR_W    = 32;
	localparam int DEF_MAX_NODES = 65536;
	localparam int DEF_ATTR_BITS = 32;

	localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(65536);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic cap;
		logic clr_wr;
		logic node_wr;
		logic node_rd;
		logic best_rd_load;
		logic best_rd_walk;
		logic best_wr;
		logic walk_adv;
		logic res_err;
		logic res_root;
		logic res_attr;
	} mtev_cmd_t;

	typedef struct packed {
		logic node_ok;
		logic upd;
		logic greater;
		logic par_oob;
		logic par_root;
		logic best_other;
		logic step_end;
		logic clr_last;
	} mtev_st_t;

endpackage
`default_nettype wire

FILE: src/mtev_ctrl.sv
// mtev_ctrl: sequencer for the clear pass, node loads and leaf walks.
// Depends on mtev_pkg; drives mtev_dp through mtev_cmd_t.
`default_nettype none
module mtev_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               cmd_in,
	input  wire mtev_pkg::mtev_st_t st,
	output mtev_pkg::mtev_cmd_t     cmd,
	output logic                    busy,
	output logic                    done
);
	import mtev_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LD_WR,
		S_LD_CMP,
		S_Q_CHK,
		S_Q_PAR,
		S_Q_BEST
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   res_any;

	always_comb begin
		cmd = '0;
		cmd.cap = start && !busy_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			S_IDLE: begin
			end
			S_LD_WR: begin
				cmd.node_wr      = st.node_ok;
				cmd.best_rd_load = 1'b1;
			end
			S_LD_CMP: begin
				cmd.best_wr = st.greater;
			end
			S_Q_CHK: begin
				cmd.node_rd = st.node_ok;
				cmd.res_err = !st.node_ok;
			end
			S_Q_PAR: begin
				cmd.res_err      = st.par_oob;
				cmd.best_rd_walk = !st.par_oob;
			end
			S_Q_BEST: begin
				priority if (st.par_root) begin
					cmd.res_root = 1'b1;
				end else if (st.best_other) begin
					cmd.res_attr = 1'b1;
				end else if (st.step_end) begin
					cmd.res_err = 1'b1;
				end else begin
					cmd.walk_adv = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_any = cmd.res_err || cmd.res_root || cmd.res_attr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= res_any;
			unique case (state_q)
				S_CLEAR: begin
					if (st.clr_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (cmd.cap) begin
						state_q <= (cmd_in == CMD_QUERY) ? S_Q_CHK : S_LD_WR;
						busy_q  <= 1'b1;
					end
				end
				S_LD_WR: begin
					if (st.upd) begin
						state_q <= S_LD_CMP;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_LD_CMP: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				S_Q_CHK: begin
					if (st.node_ok) begin
						state_q <= S_Q_PAR;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_Q_PAR: begin
					if (st.par_oob) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_Q_BEST;
					end
				end
				S_Q_BEST: begin
					if (res_any) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_Q_PAR;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

`ifndef SYNTH
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("result strobe while busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe longer than one cycle");
	a_cap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cap |=> busy_q && !done_q) else $error("transfer not followed by busy");
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> busy_q && !cmd.cap) else $error("transfer during clear pass");
`endif

endmodule
`default_nettype wire

FILE: src/mtev_dp.sv
// mtev_dp: node and best-child memories, item registers, walk state, result regs.
// Depends on mtev_pkg; controlled by mtev_ctrl.
`default_nettype none
module mtev_dp #(
	parameter int MAX_NODES = mtev_pkg::DEF_MAX_NODES,
	parameter int ATTR_BITS = mtev_pkg::DEF_ATTR_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mtev_pkg::mtev_cmd_t                 cmd,
	output mtev_pkg::mtev_st_t                       st,
	input  wire logic [mtev_pkg::NODE_W-1:0]         node_in,
	input  wire logic [mtev_pkg::NODE_W-1:0]         parent_in,
	input  wire logic [mtev_pkg::OUT_ATTR_W-1:0]     attribute_in,
	input  wire logic                                last_in,
	input  wire logic                                cfg_we,
	input  wire logic [mtev_pkg::CNT_W-1:0]          cfg_wdata,
	output logic      [mtev_pkg::NODE_W-1:0]         leaf,
	output logic      [mtev_pkg::OUT_ATTR_W-1:0]     ext_value,
	output logic                                     walk_error,
	output logic                                     last_out
);
	import mtev_pkg::*;

	localparam int IDX_W   = $clog2(MAX_NODES);
	localparam int ENT_W   = NODE_W + ATTR_BITS;
	localparam int CNT_MAX = (1 << CNT_W) - 1;
	localparam logic [CNT_W-1:0] CLIP = CNT_W'((MAX_NODES < CNT_MAX) ? MAX_NODES : CNT_MAX);
	localparam logic [CNT_W-1:0] LIM_RST = (NODE_COUNT_RST > CLIP) ? CLIP : NODE_COUNT_RST;
	localparam logic [IDX_W-1:0] CLR_END = IDX_W'(MAX_NODES - 1);

	logic [ENT_W-1:0] node_mem [MAX_NODES];
	logic [ENT_W-1:0] best_mem [MAX_NODES];

	logic [CNT_W-1:0]     lim_q;
	logic [IDX_W-1:0]     clr_q;
	logic [NODE_W-1:0]    node_q;
	logic [NODE_W-1:0]    parent_q;
	logic [ATTR_BITS-1:0] attr_q;
	logic                 last_q;
	logic [NODE_W-1:0]    cur_q;
	logic [CNT_W-1:0]     step_q;
	logic [ENT_W-1:0]     nrd_q;
	logic [ENT_W-1:0]     brd_q;
	logic [NODE_W-1:0]    leaf_q;
	logic [ATTR_BITS-1:0] ext_q;
	logic                 err_q;
	logic                 lastout_q;

	logic [NODE_W-1:0]    nrd_par;
	logic [ATTR_BITS-1:0] nrd_attr;
	logic [NODE_W-1:0]    brd_idx;
	logic [ATTR_BITS-1:0] brd_attr;
	logic [IDX_W-1:0]     nrd_addr;
	logic [IDX_W-1:0]     brd_addr;
	logic                 best_we;
	logic [IDX_W-1:0]     bwr_addr;
	logic [ENT_W-1:0]     bwr_data;
	logic                 res_any;

	assign nrd_par  = nrd_q[ENT_W-1 -: NODE_W];
	assign nrd_attr = nrd_q[ATTR_BITS-1:0];
	assign brd_idx  = brd_q[ENT_W-1 -: NODE_W];
	assign brd_attr = brd_q[ATTR_BITS-1:0];
	assign res_any  = cmd.res_err || cmd.res_root || cmd.res_attr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIM_RST;
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				lim_q <= (cfg_wdata > CLIP) ? CLIP : cfg_wdata;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			node_q   <= node_in;
			parent_q <= parent_in;
			attr_q   <= ATTR_BITS'(attribute_in);
			last_q   <= last_in;
			cur_q    <= node_in;
			step_q   <= '0;
		end else if (cmd.walk_adv) begin
			cur_q  <= nrd_par;
			step_q <= step_q + CNT_W'(1);
		end
		if (res_any) begin
			leaf_q    <= node_q;
			lastout_q <= last_q;
			err_q     <= cmd.res_err;
			priority if (cmd.res_err) begin
				ext_q <= '0;
			end else if (cmd.res_root) begin
				ext_q <= brd_attr;
			end else begin
				ext_q <= nrd_attr;
			end
		end
	end

	// node entries: {parent, attribute}
	assign nrd_addr = cmd.walk_adv ? IDX_W'(nrd_par) : IDX_W'(cur_q);

	always_ff @(posedge clk) begin
		if (cmd.node_wr) begin
			node_mem[IDX_W'(node_q)] <= {parent_q, attr_q};
		end
		if (cmd.node_rd || cmd.walk_adv) begin
			nrd_q <= node_mem[nrd_addr];
		end
	end

	// best child entries: {index, attribute}
	assign best_we  = cmd.clr_wr || cmd.best_wr;
	assign bwr_addr = cmd.clr_wr ? clr_q : IDX_W'(parent_q);
	assign bwr_data = cmd.clr_wr ? '0 : {node_q, attr_q};
	assign brd_addr = cmd.best_rd_walk ? IDX_W'(nrd_par) : IDX_W'(parent_q);

	always_ff @(posedge clk) begin
		if (best_we) begin
			best_mem[bwr_addr] <= bwr_data;
		end
		if (cmd.best_rd_load || cmd.best_rd_walk) begin
			brd_q <= best_mem[brd_addr];
		end
	end

	always_comb begin
		st.node_ok    = CNT_W'(node_q) < lim_q;
		st.upd        = st.node_ok && (parent_q != node_q) && (CNT_W'(parent_q) < lim_q);
		st.greater    = attr_q > brd_attr;
		st.par_oob    = CNT_W'(nrd_par) >= lim_q;
		st.par_root   = nrd_par == cur_q;
		st.best_other = brd_idx != cur_q;
		st.step_end   = (step_q + CNT_W'(1)) >= lim_q;
		st.clr_last   = clr_q == CLR_END;
	end

	assign leaf       = leaf_q;
	assign ext_value  = OUT_ATTR_W'(ext_q);
	assign walk_error = err_q;
	assign last_out   = lastout_q;

endmodule
`default_nettype wire

FILE: src/max_tree_extinction_values.sv
// max_tree_extinction_values: top level, controller plus datapath.
// Depends on mtev_pkg, mtev_ctrl and mtev_dp.
//
// Usage:
//   Command channel: an item transfers on a clock edge with start high and
//   busy low. cmd LOAD stores node's parent and attribute and updates the
//   parent's best child; cmd QUERY walks from leaf node toward the root.
//   Loads produce nothing. Each query produces one result on leaf, ext_value,
//   walk_error and last_out, valid for exactly one cycle while done is high.
//   The receiver cannot hold results off; done never lasts past one cycle.
//   Config: cfg_we high writes cfg_wdata, clipped to MAX_NODES, into node_count; write only while idle.
// Sequence:
//   Load: LD_WR writes the node entry and reads the parent's best child; LD_CMP follows
//   when the parent's best child is compared (read-modify-write on the best-child memory).
//   Query: walks toward the root, one step per ancestor visited; each step is
//   a node memory read followed by a best-child memory read. An out-of-range
//   parent ends the walk with an error before its best-child read.
// Reset: arst_n clears control state, then a clearing pass over every entry zeroes
//   the best-child memory, busy high. node_count resets to min(65536, MAX_NODES).
`default_nettype none
module max_tree_extinction_values #(
	parameter int MAX_NODES = mtev_pkg::DEF_MAX_NODES,
	parameter int ATTR_BITS = mtev_pkg::DEF_ATTR_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            cmd,
	input  wire logic [mtev_pkg::NODE_W-1:0]     node,
	input  wire logic [mtev_pkg::NODE_W-1:0]     parent,
	input  wire logic [mtev_pkg::OUT_ATTR_W-1:0] attribute,
	input  wire logic                            last_leaf,
	input  wire logic                            cfg_we,
	input  wire logic [mtev_pkg::CNT_W-1:0]      cfg_wdata,
	output logic                                 done,
	output logic [mtev_pkg::NODE_W-1:0]          leaf,
	output logic [mtev_pkg::OUT_ATTR_W-1:0]      ext_value,
	output logic                                 walk_error,
	output logic                                 last_out
);
	import mtev_pkg::*;

	mtev_cmd_t dp_cmd;
	mtev_st_t  dp_st;

	mtev_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd_in (cmd),
		.st     (dp_st),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	mtev_dp #(
		.MAX_NODES (MAX_NODES),
		.ATTR_BITS (ATTR_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.st           (dp_st),
		.node_in      (node),
		.parent_in    (parent),
		.attribute_in (attribute),
		.last_in      (last_leaf),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.leaf         (leaf),
		.ext_value    (ext_value),
		.walk_error   (walk_error),
		.last_out     (last_out)
	);

endmodule
`default_nettype wire
